[rtl/core/pbrd_pkg.sv]
// Shared types and constants for the run decoder.
// Used by the front parser, the command queue, the back emitter and the top level.
// No dependencies.
`default_nettype none

package pbrd_pkg;

    // Run kind in the top two bits of a flag byte.
    localparam logic [1:0] KindLit  = 2'b00;  // literal bytes follow
    localparam logic [1:0] KindRep1 = 2'b01;  // one byte repeated
    localparam logic [1:0] KindPat  = 2'b10;  // four-byte pattern repeated
    localparam logic [1:0] KindRep4 = 2'b11;  // one byte repeated as words

    // Result status codes.
    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StOverrun  = 2'd1;
    localparam logic [1:0] StEndInRun = 2'd2;

    // Bytes per result word.
    localparam logic [2:0] NbNone = 3'd0;
    localparam logic [2:0] NbByte = 3'd1;
    localparam logic [2:0] NbWord = 3'd4;

    // Capacity after reset.
    localparam logic [15:0] CapReset = 16'h8000;

    // Command queue between the parser and the emitter.
    localparam int CmdDepth = 4;
    localparam int CmdPtrW  = $clog2(CmdDepth);

    // One command: a run of count words (count may be zero), then an optional
    // end-inside-run error; last says the source byte closed the stream.
    typedef struct packed {
        logic [31:0] word;
        logic        wide;
        logic [6:0]  count;
        logic        last;
        logic        err2;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/core/pbrd_ifs.sv]
// Valid/ready channel interfaces for the source bytes and the decoded results.
// Depends on nothing; used by the front, back and top level.
`default_nettype none

interface pbrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       end_of_source;

    modport source (output valid, output src_byte, output end_of_source, input ready);
    modport sink (input valid, input src_byte, input end_of_source, output ready);
endinterface

interface pbrd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_data;
    logic [2:0]  out_bytes;
    logic        final_res;
    logic [1:0]  status;
    logic [15:0] total_written;

    modport source (
        output valid, output out_data, output out_bytes, output final_res,
        output status, output total_written, input ready
    );
    modport sink (
        input valid, input out_data, input out_bytes, input final_res,
        input status, input total_written, output ready
    );
endinterface

`default_nettype wire

[rtl/core/pbrd_front.sv]
// Front parser: accepts source bytes, tracks the run being parsed and turns
// each byte into at most one command. Depends on pbrd_pkg and pbrd_in_if.
`default_nettype none

module pbrd_front
    import pbrd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    pbrd_in_if.sink    i_src,
    input  wire        i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        PH_FLAG = 3'd0,
        PH_LIT  = 3'd1,
        PH_REP1 = 3'd2,
        PH_PAT  = 3'd3,
        PH_REP4 = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [6:0]  r_run_left, n_run_left;
    logic [23:0] r_pattern, n_pattern;
    logic [1:0]  r_fill, n_fill;
    logic        accept;
    logic [7:0]  b;
    logic        e;

    assign i_src.ready = !i_full;
    assign accept      = i_src.valid && !i_full;
    assign b           = i_src.src_byte;
    assign e           = i_src.end_of_source;

    // Classify the accepted byte by phase and build its command.
    always_comb begin
        n_phase    = r_phase;
        n_run_left = r_run_left;
        n_pattern  = r_pattern;
        n_fill     = r_fill;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.last = e;
        if (accept) begin
            unique case (r_phase)
                PH_LIT: begin
                    o_push       = 1'b1;
                    o_cmd.word   = {24'd0, b};
                    o_cmd.count  = 7'd1;
                    o_cmd.err2   = e && (r_run_left != 7'd1);
                    n_run_left   = r_run_left - 7'd1;
                    if (r_run_left == 7'd1 || e) begin
                        n_phase = PH_FLAG;
                    end
                end
                PH_REP1: begin
                    o_push      = 1'b1;
                    o_cmd.word  = {24'd0, b};
                    o_cmd.count = r_run_left;
                    n_phase     = PH_FLAG;
                end
                PH_PAT: begin
                    if (r_fill != 2'd3) begin
                        n_pattern[8*r_fill +: 8] = b;
                        n_fill = r_fill + 2'd1;
                        if (e) begin
                            // Stream ends before the pattern is complete.
                            o_push     = 1'b1;
                            o_cmd.err2 = 1'b1;
                            n_phase    = PH_FLAG;
                            n_fill     = 2'd0;
                        end
                    end else begin
                        o_push      = 1'b1;
                        o_cmd.word  = {b, r_pattern};
                        o_cmd.wide  = 1'b1;
                        o_cmd.count = r_run_left;
                        n_phase     = PH_FLAG;
                        n_fill      = 2'd0;
                    end
                end
                PH_REP4: begin
                    o_push      = 1'b1;
                    o_cmd.word  = {b, b, b, b};
                    o_cmd.wide  = 1'b1;
                    o_cmd.count = r_run_left;
                    n_phase     = PH_FLAG;
                end
                default: begin
                    // Flag byte: count and run kind.
                    n_run_left = {1'b0, b[5:0]} + 7'd1;
                    n_pattern  = '0;
                    n_fill     = 2'd0;
                    unique case (b[7:6])
                        KindLit:  n_phase = PH_LIT;
                        KindRep1: n_phase = PH_REP1;
                        KindPat:  n_phase = PH_PAT;
                        KindRep4: n_phase = PH_REP4;
                        default:  n_phase = PH_FLAG;
                    endcase
                    if (e) begin
                        o_push     = 1'b1;
                        o_cmd.err2 = 1'b1;
                        n_phase    = PH_FLAG;
                    end
                end
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FLAG;
            r_run_left <= '0;
            r_pattern  <= '0;
            r_fill     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_run_left <= n_run_left;
            r_pattern  <= n_pattern;
            r_fill     <= n_fill;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pbrd_fifo.sv]
// Short command queue between the parser and the emitter.
// Depends on pbrd_pkg for the command type and depth.
`default_nettype none

module pbrd_fifo
    import pbrd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_cmd i_data,
    input  wire  i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd               r_mem [CmdDepth];
    logic [CmdPtrW-1:0] r_wr_ptr;
    logic [CmdPtrW-1:0] r_rd_ptr;
    logic [CmdPtrW:0]   r_count;

    assign o_full  = (r_count == (CmdPtrW+1)'(CmdDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage is written only; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + CmdPtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + CmdPtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (CmdPtrW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (CmdPtrW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/pbrd_back.sv]
// Back emitter: plays out commands as result words, keeps the byte count,
// checks capacity and drops commands after an overrun. Depends on pbrd_pkg
// and pbrd_out_if.
`default_nettype none

module pbrd_back
    import pbrd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [15:0] i_cap,
    input  t_cmd        i_head,
    input  wire         i_empty,
    output logic        o_pop,
    pbrd_out_if.source  o_res
);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DATA = 2'd1,
        S_ERR  = 2'd2
    } t_state;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [6:0]  r_left, n_left;
    logic [15:0] r_bw, n_bw;
    logic        r_discard, n_discard;

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;
    logic [2:0]  r_out_bytes, n_out_bytes;
    logic        r_out_final, n_out_final;
    logic [1:0]  r_out_status, n_out_status;
    logic [15:0] r_out_total, n_out_total;

    logic        slot_free;
    logic [2:0]  nb;
    logic [16:0] bw_after;
    logic        overrun;

    assign o_res.valid         = r_out_valid;
    assign o_res.out_data      = r_out_data;
    assign o_res.out_bytes     = r_out_bytes;
    assign o_res.final_res     = r_out_final;
    assign o_res.status        = r_out_status;
    assign o_res.total_written = r_out_total;

    assign slot_free = !r_out_valid || o_res.ready;
    assign nb        = r_cmd.wide ? NbWord : NbByte;
    assign bw_after  = {1'b0, r_bw} + {14'd0, nb};
    assign overrun   = bw_after > {1'b0, i_cap};

    // Command sequencing and result generation.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_left       = r_left;
        n_bw         = r_bw;
        n_discard    = r_discard;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_data   = r_out_data;
        n_out_bytes  = r_out_bytes;
        n_out_final  = r_out_final;
        n_out_status = r_out_status;
        n_out_total  = r_out_total;
        o_pop        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (r_discard) begin
                        // Dropping until the end of the stream.
                        if (i_head.last) begin
                            n_bw      = '0;
                            n_discard = 1'b0;
                        end
                    end else begin
                        n_cmd  = i_head;
                        n_left = i_head.count;
                        n_state = (i_head.count != 7'd0) ? S_DATA : S_ERR;
                    end
                end
            end
            S_DATA: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (overrun) begin
                        n_out_data   = '0;
                        n_out_bytes  = NbNone;
                        n_out_final  = 1'b1;
                        n_out_status = StOverrun;
                        n_out_total  = r_bw;
                        if (r_cmd.last) begin
                            n_bw = '0;
                        end else begin
                            n_discard = 1'b1;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_out_data   = r_cmd.word;
                        n_out_bytes  = nb;
                        n_out_final  = (r_left == 7'd1) && r_cmd.last && !r_cmd.err2;
                        n_out_status = StOk;
                        n_out_total  = bw_after[15:0];
                        n_bw         = bw_after[15:0];
                        n_left       = r_left - 7'd1;
                        if (r_left == 7'd1) begin
                            if (r_cmd.err2) begin
                                n_state = S_ERR;
                            end else begin
                                if (r_cmd.last) begin
                                    n_bw = '0;
                                end
                                n_state = S_IDLE;
                            end
                        end
                    end
                end
            end
            S_ERR: begin
                // Source ended inside a run; this always closes the stream.
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = '0;
                    n_out_bytes  = NbNone;
                    n_out_final  = 1'b1;
                    n_out_status = StEndInRun;
                    n_out_total  = r_bw;
                    n_bw         = '0;
                    n_discard    = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_bw        <= '0;
            r_discard   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_bw        <= n_bw;
            r_discard   <= n_discard;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_out_data   <= n_out_data;
        r_out_bytes  <= n_out_bytes;
        r_out_final  <= n_out_final;
        r_out_status <= n_out_status;
        r_out_total  <= n_out_total;
    end

endmodule

`default_nettype wire

[rtl/core/packbytes_run_decoder.sv]
// PackBytes run decoder, top level: capacity register, parser, command queue
// and emitter. Depends on pbrd_pkg, pbrd_ifs, pbrd_front, pbrd_fifo, pbrd_back.
//
// Usage:
// Source bytes arrive on i_src (valid/ready); a transfer takes one byte and
// its end_of_source mark. Results leave on o_res (valid/ready), one word of
// zero, one or four bytes per transfer; final_res marks the last result of a
// stream, with status and the running byte total.
// The capacity register is written with i_cfg_we/i_cfg_wdata; the user must
// write it only while idle, the block itself does not enforce this.
// The first result of a byte passes through the queue entry, the command
// register and the output register. Throughput: the parser takes one byte
// per cycle while the four-entry command queue has room. The emitter fetches
// a command only once it has finished the last one, then emits its result
// words; for long runs the output side sets the rate at one word per cycle
// while the receiver is ready.
// Reset clears the parser, the queue, the byte count and the output
// valid flag, and sets the capacity to 32768 bytes.
// A stalled receiver holds the output register; the emitter then waits,
// the queue fills and i_src.ready drops until room returns.
`default_nettype none

module packbytes_run_decoder
    import pbrd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    pbrd_in_if.sink     i_src,
    pbrd_out_if.source  o_res,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata
);

    logic [15:0] r_out_capacity;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_cmd        cmd_in;
    t_cmd        cmd_head;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= CapReset;
        end else if (i_cfg_we) begin
            r_out_capacity <= i_cfg_wdata;
        end
    end

    pbrd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (i_src),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    pbrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .i_pop   (pop),
        .o_head  (cmd_head),
        .o_full  (full),
        .o_empty (empty)
    );

    pbrd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_out_capacity),
        .i_head  (cmd_head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

[tb/sv/packbytes_run_decoder_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for packbytes_run_decoder: it sends PackBytes streams over
// the source channel and checks every decoded result against a built-in decoder.
// Depends on pbrd_pkg, pbrd_ifs and the decoder RTL.

module packbytes_run_decoder_tb;
    import pbrd_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int SettleCycles = 12;
    localparam int RandomItems  = 330;

    // Where the shadow decoder stands in the source stream.
    typedef enum logic [2:0] {PhFlag, PhLit, PhRep1, PhPat, PhRep4} t_dec_phase;

    typedef struct packed {
        logic [7:0] value;
        logic       eos;
    } t_src_item;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        fin;
        logic [1:0]  status;
        logic [15:0] total;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    pbrd_in_if  src_if ();
    pbrd_out_if res_if ();

    packbytes_run_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_src      (src_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    // Shadow decoder state and the capacity it believes is programmed.
    t_dec_phase  dec_phase;
    logic [6:0]  run_left;
    logic [31:0] pat_word;
    logic [1:0]  pat_fill;
    logic [15:0] written;
    logic        dropping;
    logic [15:0] capacity;

    t_src_item pending_q[$];
    t_word     expected_q[$];

    int error_count   = 0;
    int pushed_items  = 0;
    int decoded_items = 0;
    int sent_items    = 0;
    int words_checked = 0;
    int clean_ends    = 0;
    int overruns      = 0;
    int early_ends    = 0;
    int cycle_count   = 0;
    int gap_left      = 0;
    int burst_left    = 1;
    int recv_tick     = 0;
    int recv_mode     = 0;

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned room_left();
        return (written >= capacity) ? 0 : int'(capacity) - int'(written);
    endfunction

    task automatic clear_stream();
        dec_phase = PhFlag;
        run_left  = '0;
        pat_word  = '0;
        pat_fill  = '0;
        written   = '0;
        dropping  = 1'b0;
    endtask

    task automatic push_word(input logic [31:0] data, input logic [2:0] nb,
                             input logic fin, input logic [1:0] st);
        t_word w;
        w.data   = data;
        w.nbytes = nb;
        w.fin    = fin;
        w.status = st;
        w.total  = written;
        expected_q.push_back(w);
    endtask

    // Emits the remaining words of a repeat run; flags an overrun when room runs out.
    task automatic expand_run(input logic [31:0] word, input logic [2:0] nb,
                              output logic ovr);
        ovr = 1'b0;
        while (run_left != 0 && !ovr) begin
            if (room_left() < nb) begin
                ovr = 1'b1;
            end else begin
                written  = written + 16'(nb);
                run_left = run_left - 7'd1;
                push_word(word, nb, 1'b0, StOk);
            end
        end
    endtask

    // Works out the results that one accepted source byte causes.
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [1:0] err;
        logic       done;
        logic       ovr;
        int         start_len;
        t_word      last_w;
        err       = StOk;
        done      = 1'b0;
        ovr       = 1'b0;
        start_len = expected_q.size();
        if (dropping) begin
            if (eos) clear_stream();
        end else begin
            decoded_items++;
            case (dec_phase)
                PhLit: begin
                    if (room_left() == 0) begin
                        err = StOverrun;
                    end else begin
                        written = written + 16'd1;
                        if (run_left != 0) run_left = run_left - 7'd1;
                        push_word({24'd0, b}, NbByte, 1'b0, StOk);
                        if (run_left == 0) begin
                            dec_phase = PhFlag;
                            done      = 1'b1;
                        end else if (eos) begin
                            err = StEndInRun;
                        end
                    end
                end
                PhRep1, PhRep4: begin
                    if (dec_phase == PhRep1) expand_run({24'd0, b}, NbByte, ovr);
                    else expand_run({4{b}}, NbWord, ovr);
                    if (ovr) begin
                        err = StOverrun;
                    end else begin
                        dec_phase = PhFlag;
                        done      = 1'b1;
                    end
                end
                PhPat: begin
                    pat_word = pat_word | ({24'd0, b} << (8 * pat_fill));
                    if (pat_fill < 2'd3) begin
                        pat_fill = pat_fill + 2'd1;
                        if (eos) err = StEndInRun;
                    end else begin
                        pat_fill = '0;
                        expand_run(pat_word, NbWord, ovr);
                        if (ovr) begin
                            err = StOverrun;
                        end else begin
                            dec_phase = PhFlag;
                            done      = 1'b1;
                        end
                    end
                end
                default: begin
                    run_left = {1'b0, b[5:0]} + 7'd1;
                    pat_word = '0;
                    pat_fill = '0;
                    case (b[7:6])
                        KindLit:  dec_phase = PhLit;
                        KindRep1: dec_phase = PhRep1;
                        KindPat:  dec_phase = PhPat;
                        default:  dec_phase = PhRep4;
                    endcase
                    if (eos) err = StEndInRun;
                end
            endcase

            // Close the stream on an error or on a clean end.
            if (err != StOk) begin
                push_word(32'd0, NbNone, 1'b1, err);
                if (eos) clear_stream();
                else dropping = 1'b1;
            end else if (done && eos) begin
                if (expected_q.size() > start_len) begin
                    last_w     = expected_q.pop_back();
                    last_w.fin = 1'b1;
                    expected_q.push_back(last_w);
                end
                clear_stream();
            end
        end
    endtask

    // Source driver: bursts of transfers with random gaps; a pending byte is held
    // until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_if.valid         <= 1'b0;
            src_if.src_byte      <= 8'd0;
            src_if.end_of_source <= 1'b0;
        end else begin
            if (src_if.valid && src_if.ready) begin
                decode_byte(src_if.src_byte, src_if.end_of_source);
                void'(pending_q.pop_front());
                sent_items++;
            end
            if (!(src_if.valid && !src_if.ready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    src_if.valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    src_if.valid         <= 1'b1;
                    src_if.src_byte      <= pending_q[0].value;
                    src_if.end_of_source <= pending_q[0].eos;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    src_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_word();
        t_word exp_w;
        if (res_if.final_res) begin
            if (res_if.status == StOk) clean_ends++;
            else if (res_if.status == StOverrun) overruns++;
            else early_ends++;
        end
        if (expected_q.size() == 0) begin
            $display("%0t: result with none expected: data %h bytes %0d final %0d status %0d",
                     $time, res_if.out_data, res_if.out_bytes, res_if.final_res,
                     res_if.status);
            error_count++;
        end else begin
            exp_w = expected_q.pop_front();
            words_checked++;
            if (res_if.out_data !== exp_w.data) begin
                $display("%0t: out_data expected %h, actual %h",
                         $time, exp_w.data, res_if.out_data);
                error_count++;
            end
            if (res_if.out_bytes !== exp_w.nbytes) begin
                $display("%0t: out_bytes expected %0d, actual %0d",
                         $time, exp_w.nbytes, res_if.out_bytes);
                error_count++;
            end
            if (res_if.final_res !== exp_w.fin) begin
                $display("%0t: final_res expected %0d, actual %0d",
                         $time, exp_w.fin, res_if.final_res);
                error_count++;
            end
            if (res_if.status !== exp_w.status) begin
                $display("%0t: status expected %0d, actual %0d",
                         $time, exp_w.status, res_if.status);
                error_count++;
            end
            if (res_if.total_written !== exp_w.total) begin
                $display("%0t: total_written expected %0d, actual %0d",
                         $time, exp_w.total, res_if.total_written);
                error_count++;
            end
        end
    endtask

    // Result monitor; the receiver switches between stall patterns chosen at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) check_word();
            recv_tick++;
            if (recv_tick % 32 == 0) recv_mode = $urandom_range(0, 3);
            case (recv_mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= 1'($urandom_range(0, 1));
                2:       res_if.ready <= ($urandom_range(0, 3) == 0);
                default: res_if.ready <= ((recv_tick % 16) < 8);
            endcase
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] make_flag(input logic [1:0] kind, input int count);
        logic [5:0] low;
        low = 6'(count - 1);
        return {kind, low};
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic eos);
        t_src_item it;
        it.value = b;
        it.eos   = eos;
        pending_q.push_back(it);
        pushed_items++;
    endtask

    // Run lengths lean small, with a few up to the full 64.
    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 6);
        if (r < 9) return $urandom_range(7, 24);
        return $urandom_range(25, 64);
    endfunction

    function automatic int data_len(input logic [1:0] kind, input int count);
        if (kind == KindLit) return count;
        if (kind == KindPat) return 4;
        return 1;
    endfunction

    task automatic add_run(input logic [1:0] kind, input int count, input logic last);
        int n;
        n = data_len(kind, count);
        add_byte(make_flag(kind, count), 1'b0);
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), last && (i == n - 1));
    endtask

    task automatic add_stream();
        int nruns;
        nruns = $urandom_range(1, 4);
        for (int k = 0; k < nruns; k++)
            add_run(2'($urandom_range(0, 3)), pick_count(), k == nruns - 1);
    endtask

    // A run cut short: end of source lands on the flag or on an early data byte.
    task automatic add_broken();
        logic [1:0] kind;
        int         count;
        int         keep;
        kind  = 2'($urandom_range(0, 3));
        count = pick_count();
        keep  = $urandom_range(0, data_len(kind, count) - 1);
        add_byte(make_flag(kind, count), keep == 0);
        for (int i = 0; i < keep; i++) add_byte(8'($urandom_range(0, 255)), i == keep - 1);
    endtask

    function automatic logic [15:0] pick_capacity();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r == 2) return CapReset;
        if (r < 5) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(1, 200));
    endfunction

    // Holds off until every byte is taken and every result has come, then lets
    // bytes without results finish inside the block.
    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [15:0] cap);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        capacity  = cap;
    endtask

    initial begin
        int phase_end;
        int r;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 16'd0;
        src_if.valid         = 1'b0;
        src_if.src_byte      = 8'd0;
        src_if.end_of_source = 1'b0;
        res_if.ready         = 1'b0;
        capacity             = CapReset;
        clear_stream();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Clean stream at the reset capacity, one run of each kind, longest counts for the byte repeat runs.
        add_byte(make_flag(KindLit, 1), 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(make_flag(KindRep1, 64), 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(make_flag(KindPat, 1), 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h5A, 1'b0);
        add_byte(make_flag(KindRep4, 64), 1'b0);
        add_byte(8'hA5, 1'b1);
        // Source ends on a flag, inside a literal run, and inside a pattern.
        add_byte(make_flag(KindLit, 3), 1'b1);
        add_byte(make_flag(KindLit, 4), 1'b0);
        add_byte(8'h3C, 1'b1);
        add_byte(make_flag(KindPat, 2), 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'h7E, 1'b1);
        wait_drained();

        // No room at all: the first literal byte overruns, the rest is dropped up to the end.
        set_capacity(16'd0);
        add_byte(make_flag(KindLit, 2), 1'b0);
        add_byte(8'h11, 1'b0);
        add_byte(8'h22, 1'b0);
        add_byte(make_flag(KindRep4, 1), 1'b1);
        wait_drained();

        // Open a stream at full capacity, then lower the capacity below its count.
        set_capacity(16'hFFFF);
        add_byte(make_flag(KindRep1, 8), 1'b0);
        add_byte(8'h9C, 1'b0);
        wait_drained();
        set_capacity(16'd5);
        add_byte(make_flag(KindRep4, 1), 1'b0);
        add_byte(8'h44, 1'b0);
        add_byte(make_flag(KindRep1, 8), 1'b1);
        // Fresh stream: five words fit, then the run overruns.
        add_byte(make_flag(KindRep1, 8), 1'b0);
        add_byte(8'hE7, 1'b1);
        wait_drained();

        // Random phases, each at a new capacity; streams may span a capacity change.
        r = decoded_items;
        while (decoded_items < r + RandomItems) begin
            set_capacity(pick_capacity());
            phase_end = pushed_items + $urandom_range(20, 45);
            while (pushed_items < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: add_stream();
                    7, 8:                add_broken();
                    default: begin
                        repeat ($urandom_range(1, 4))
                            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
                    end
                endcase
            end
            wait_drained();
        end

        $display("Sent %0d source bytes (%0d decoded, rest dropped after errors).",
                 sent_items, decoded_items);
        $display("Checked %0d results: %0d clean ends, %0d overruns, %0d early ends.",
                 words_checked, clean_ends, overruns, early_ends);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches found.", error_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
